### design/amf0_stream_tokenizer_top_defines.svh
// Assertion macros for the AMF0 stream tokenizer checker.
// Expects signals clk and rst_n in the scope where the macros are used.
`ifndef AMF0_STREAM_TOKENIZER_TOP_DEFINES_SVH
`define AMF0_STREAM_TOKENIZER_TOP_DEFINES_SVH

// same-cycle implication
`define AMF0_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define AMF0_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/amf0_tok_pkg.sv
// Package for the AMF0 stream tokenizer: widths, role codes, phase codes, types.
// No dependencies.
`default_nettype none

package amf0_tok_pkg;

    localparam int unsigned MAX_MESSAGE_DEFAULT = 65535;

    localparam int unsigned ROLE_W  = 4;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned LEFT_W  = 16;
    localparam int unsigned NUM_W   = 64;
    localparam int unsigned PHASE_W = 4;

    // result roles
    localparam logic [ROLE_W-1:0] ROLE_NUM_MARKER  = 4'd0;
    localparam logic [ROLE_W-1:0] ROLE_NUM_BYTE    = 4'd1;
    localparam logic [ROLE_W-1:0] ROLE_BOOL_MARKER = 4'd2;
    localparam logic [ROLE_W-1:0] ROLE_BOOL_BYTE   = 4'd3;
    localparam logic [ROLE_W-1:0] ROLE_STR_MARKER  = 4'd4;
    localparam logic [ROLE_W-1:0] ROLE_STR_LEN     = 4'd5;
    localparam logic [ROLE_W-1:0] ROLE_STR_BYTE    = 4'd6;
    localparam logic [ROLE_W-1:0] ROLE_OBJ_MARKER  = 4'd7;
    localparam logic [ROLE_W-1:0] ROLE_NULL        = 4'd8;
    localparam logic [ROLE_W-1:0] ROLE_NAME_LEN    = 4'd9;
    localparam logic [ROLE_W-1:0] ROLE_NAME_BYTE   = 4'd10;
    localparam logic [ROLE_W-1:0] ROLE_OBJ_END     = 4'd11;
    localparam logic [ROLE_W-1:0] ROLE_UNKNOWN     = 4'd12;
    localparam logic [ROLE_W-1:0] ROLE_SKIPPED     = 4'd13;

    // AMF0 type markers
    localparam logic [BYTE_W-1:0] MARK_NUMBER  = 8'h00;
    localparam logic [BYTE_W-1:0] MARK_BOOLEAN = 8'h01;
    localparam logic [BYTE_W-1:0] MARK_STRING  = 8'h02;
    localparam logic [BYTE_W-1:0] MARK_OBJECT  = 8'h03;
    localparam logic [BYTE_W-1:0] MARK_NULL    = 8'h05;
    localparam logic [BYTE_W-1:0] MARK_OBJ_END = 8'h09;

    localparam logic [LEFT_W-1:0] NUM_BYTES = 16'd8;

    // parser phases
    localparam logic [PHASE_W-1:0] PH_MARKER  = 4'd0;
    localparam logic [PHASE_W-1:0] PH_NUM     = 4'd1;
    localparam logic [PHASE_W-1:0] PH_BOOL    = 4'd2;
    localparam logic [PHASE_W-1:0] PH_SLEN_HI = 4'd3;
    localparam logic [PHASE_W-1:0] PH_SLEN_LO = 4'd4;
    localparam logic [PHASE_W-1:0] PH_STR     = 4'd5;
    localparam logic [PHASE_W-1:0] PH_NLEN_HI = 4'd6;
    localparam logic [PHASE_W-1:0] PH_NLEN_LO = 4'd7;
    localparam logic [PHASE_W-1:0] PH_NAME    = 4'd8;
    localparam logic [PHASE_W-1:0] PH_ZNAME   = 4'd9;
    localparam logic [PHASE_W-1:0] PH_ENDB    = 4'd10;
    localparam logic [PHASE_W-1:0] PH_SKIP    = 4'd11;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic               object_open;
        logic               member_pending;
        logic [LEFT_W-1:0]  bytes_to_go;
        logic [BYTE_W-1:0]  length_high;
        logic [NUM_W-1:0]   number_shift;
    } amf0_state_t;

    typedef struct packed {
        logic [ROLE_W-1:0] role;
        logic [BYTE_W-1:0] data_byte;
        logic              in_object;
        logic              field_done;
        logic [NUM_W-1:0]  number_bits;
        logic [LEFT_W-1:0] length_value;
        logic              error;
    } amf0_result_t;

    localparam amf0_state_t STATE_RESET = '{
        phase:          PH_MARKER,
        object_open:    1'b0,
        member_pending: 1'b0,
        bytes_to_go:    '0,
        length_high:    '0,
        number_shift:   '0
    };

endpackage

`default_nettype wire

### design/amf0_tok_if.sv
// Valid/ready channel interfaces for the AMF0 stream tokenizer.
// Depends on amf0_tok_pkg.
`default_nettype none

interface amf0_tok_in_if;
    logic                             valid;
    logic                             ready;
    logic [amf0_tok_pkg::BYTE_W-1:0]  byte_in;
    logic [amf0_tok_pkg::LEFT_W-1:0]  bytes_left;

    modport source (output valid, output byte_in, output bytes_left, input ready);
    modport sink   (input valid, input byte_in, input bytes_left, output ready);
endinterface

interface amf0_tok_out_if;
    logic                             valid;
    logic                             ready;
    logic [amf0_tok_pkg::ROLE_W-1:0]  role;
    logic [amf0_tok_pkg::BYTE_W-1:0]  data_byte;
    logic                             in_object;
    logic                             field_done;
    logic [amf0_tok_pkg::NUM_W-1:0]   number_bits;
    logic [amf0_tok_pkg::LEFT_W-1:0]  length_value;
    logic                             error;

    modport source (output valid, output role, output data_byte, output in_object,
                    output field_done, output number_bits, output length_value,
                    output error, input ready);
    modport sink   (input valid, input role, input data_byte, input in_object,
                    input field_done, input number_bits, input length_value,
                    input error, output ready);
endinterface

`default_nettype wire

### design/amf0_tok_step.sv
// Next-state and result logic for one message byte of the AMF0 tokenizer.
// Depends on amf0_tok_pkg.
`default_nettype none

module amf0_tok_step #(
    parameter int unsigned MAX_MESSAGE = amf0_tok_pkg::MAX_MESSAGE_DEFAULT
) (
    input  wire logic [amf0_tok_pkg::BYTE_W-1:0] byte_in,
    input  wire logic [amf0_tok_pkg::LEFT_W-1:0] bytes_left,
    input  wire amf0_tok_pkg::amf0_state_t       cur,
    output amf0_tok_pkg::amf0_state_t            nxt,
    output amf0_tok_pkg::amf0_result_t           res
);

    localparam logic [amf0_tok_pkg::LEFT_W-1:0] LEFT_MAX =
        amf0_tok_pkg::LEFT_W'(MAX_MESSAGE - 1);

    logic [amf0_tok_pkg::LEFT_W-1:0] left;
    logic [amf0_tok_pkg::LEFT_W-1:0] len;
    logic [amf0_tok_pkg::LEFT_W-1:0] cnt_dec;
    logic                            cnt_last;
    logic                            member;
    logic                            do_marker;
    logic                            after_value_obj;

    assign left     = (bytes_left > LEFT_MAX) ? LEFT_MAX : bytes_left;
    assign len      = {cur.length_high, byte_in};
    assign cnt_last = (cur.bytes_to_go <= amf0_tok_pkg::LEFT_W'(1));
    assign cnt_dec  = cnt_last ? '0 : cur.bytes_to_go - amf0_tok_pkg::LEFT_W'(1);
    // a zero-length name followed by anything but the end byte is a member marker
    assign do_marker = (cur.phase == amf0_tok_pkg::PH_MARKER) ||
                       ((cur.phase == amf0_tok_pkg::PH_ZNAME) &&
                        (byte_in != amf0_tok_pkg::MARK_OBJ_END));
    assign member   = (cur.phase == amf0_tok_pkg::PH_ZNAME) ? 1'b1 : cur.member_pending;
    assign after_value_obj = cur.object_open;

    always_comb
    begin
        nxt = cur;
        res = '0;
        res.role      = amf0_tok_pkg::ROLE_SKIPPED;
        res.data_byte = byte_in;

        if (do_marker)
        begin
            res.in_object      = member;
            res.field_done     = 1'b1;
            nxt.member_pending = member;
            unique case (byte_in)
                amf0_tok_pkg::MARK_NUMBER:
                begin
                    res.role         = amf0_tok_pkg::ROLE_NUM_MARKER;
                    nxt.phase        = amf0_tok_pkg::PH_NUM;
                    nxt.bytes_to_go  = amf0_tok_pkg::NUM_BYTES;
                    nxt.number_shift = '0;
                end
                amf0_tok_pkg::MARK_BOOLEAN:
                begin
                    res.role  = amf0_tok_pkg::ROLE_BOOL_MARKER;
                    nxt.phase = amf0_tok_pkg::PH_BOOL;
                end
                amf0_tok_pkg::MARK_STRING:
                begin
                    res.role  = amf0_tok_pkg::ROLE_STR_MARKER;
                    nxt.phase = amf0_tok_pkg::PH_SLEN_HI;
                end
                amf0_tok_pkg::MARK_OBJECT:
                begin
                    res.role           = amf0_tok_pkg::ROLE_OBJ_MARKER;
                    nxt.object_open    = 1'b1;
                    nxt.member_pending = 1'b0;
                    nxt.phase          = amf0_tok_pkg::PH_NLEN_HI;
                end
                amf0_tok_pkg::MARK_NULL:
                begin
                    res.role           = amf0_tok_pkg::ROLE_NULL;
                    nxt.member_pending = 1'b0;
                    nxt.phase          = after_value_obj ? amf0_tok_pkg::PH_NLEN_HI
                                                         : amf0_tok_pkg::PH_MARKER;
                end
                default:
                begin
                    res.role           = amf0_tok_pkg::ROLE_UNKNOWN;
                    res.error          = 1'b1;
                    res.field_done     = 1'b0;
                    nxt.object_open    = 1'b0;
                    nxt.member_pending = 1'b0;
                    nxt.phase          = amf0_tok_pkg::PH_SKIP;
                end
            endcase
        end
        else
        begin
            unique case (cur.phase)
                amf0_tok_pkg::PH_NUM:
                begin
                    res.role         = amf0_tok_pkg::ROLE_NUM_BYTE;
                    res.in_object    = cur.member_pending;
                    nxt.number_shift = {cur.number_shift[amf0_tok_pkg::NUM_W-9:0], byte_in};
                    res.number_bits  = nxt.number_shift;
                    nxt.bytes_to_go  = cnt_dec;
                    if (cnt_last)
                    begin
                        res.field_done     = 1'b1;
                        nxt.member_pending = 1'b0;
                        nxt.phase = after_value_obj ? amf0_tok_pkg::PH_NLEN_HI
                                                    : amf0_tok_pkg::PH_MARKER;
                    end
                end
                amf0_tok_pkg::PH_BOOL:
                begin
                    res.role           = amf0_tok_pkg::ROLE_BOOL_BYTE;
                    res.in_object      = cur.member_pending;
                    res.field_done     = 1'b1;
                    nxt.member_pending = 1'b0;
                    nxt.phase = after_value_obj ? amf0_tok_pkg::PH_NLEN_HI
                                                : amf0_tok_pkg::PH_MARKER;
                end
                amf0_tok_pkg::PH_SLEN_HI:
                begin
                    res.role        = amf0_tok_pkg::ROLE_STR_LEN;
                    res.in_object   = cur.member_pending;
                    nxt.length_high = byte_in;
                    nxt.phase       = amf0_tok_pkg::PH_SLEN_LO;
                end
                amf0_tok_pkg::PH_SLEN_LO:
                begin
                    res.role         = amf0_tok_pkg::ROLE_STR_LEN;
                    res.in_object    = cur.member_pending;
                    res.field_done   = 1'b1;
                    res.length_value = len;
                    nxt.bytes_to_go  = len;
                    if (len == '0)
                    begin
                        nxt.member_pending = 1'b0;
                        nxt.phase = after_value_obj ? amf0_tok_pkg::PH_NLEN_HI
                                                    : amf0_tok_pkg::PH_MARKER;
                    end
                    else
                    begin
                        nxt.phase = amf0_tok_pkg::PH_STR;
                    end
                end
                amf0_tok_pkg::PH_STR:
                begin
                    res.role        = amf0_tok_pkg::ROLE_STR_BYTE;
                    res.in_object   = cur.member_pending;
                    nxt.bytes_to_go = cnt_dec;
                    if (cnt_last)
                    begin
                        res.field_done     = 1'b1;
                        nxt.member_pending = 1'b0;
                        nxt.phase = after_value_obj ? amf0_tok_pkg::PH_NLEN_HI
                                                    : amf0_tok_pkg::PH_MARKER;
                    end
                end
                amf0_tok_pkg::PH_NLEN_HI:
                begin
                    res.role        = amf0_tok_pkg::ROLE_NAME_LEN;
                    res.in_object   = 1'b1;
                    nxt.length_high = byte_in;
                    nxt.phase       = amf0_tok_pkg::PH_NLEN_LO;
                end
                amf0_tok_pkg::PH_NLEN_LO:
                begin
                    res.role         = amf0_tok_pkg::ROLE_NAME_LEN;
                    res.in_object    = 1'b1;
                    res.field_done   = 1'b1;
                    res.length_value = len;
                    // a name reaching to or past the message end closes the object
                    priority if (len >= left)
                    begin
                        nxt.object_open    = 1'b0;
                        nxt.member_pending = 1'b0;
                        nxt.phase          = amf0_tok_pkg::PH_ENDB;
                    end
                    else if (len == '0)
                    begin
                        nxt.phase = amf0_tok_pkg::PH_ZNAME;
                    end
                    else
                    begin
                        nxt.bytes_to_go = len;
                        nxt.phase       = amf0_tok_pkg::PH_NAME;
                    end
                end
                amf0_tok_pkg::PH_NAME:
                begin
                    res.role        = amf0_tok_pkg::ROLE_NAME_BYTE;
                    res.in_object   = 1'b1;
                    nxt.bytes_to_go = cnt_dec;
                    if (cnt_last)
                    begin
                        res.field_done     = 1'b1;
                        nxt.member_pending = 1'b1;
                        nxt.phase          = amf0_tok_pkg::PH_MARKER;
                    end
                end
                amf0_tok_pkg::PH_ZNAME:
                begin
                    // only the end byte reaches here
                    res.role           = amf0_tok_pkg::ROLE_OBJ_END;
                    res.field_done     = 1'b1;
                    nxt.object_open    = 1'b0;
                    nxt.member_pending = 1'b0;
                    nxt.phase          = amf0_tok_pkg::PH_MARKER;
                end
                amf0_tok_pkg::PH_ENDB:
                begin
                    res.role       = amf0_tok_pkg::ROLE_OBJ_END;
                    res.field_done = 1'b1;
                    nxt.phase      = amf0_tok_pkg::PH_MARKER;
                end
                default:
                begin
                    res.role = amf0_tok_pkg::ROLE_SKIPPED;
                end
            endcase
        end

        if (left == '0)
        begin
            nxt = amf0_tok_pkg::STATE_RESET;
        end
    end

endmodule

`default_nettype wire

### design/amf0_stream_tokenizer_top.sv
// Top level of the AMF0 stream tokenizer: input register, parser state, result register.
// Depends on amf0_tok_pkg, amf0_tok_if and amf0_tok_step.
//
//   channel   dir  payload                                           handshake
//   in_chan   in   byte_in, bytes_left                               valid/ready
//   out_chan  out  role, data_byte, in_object, field_done,
//                  number_bits, length_value, error                  valid/ready
//
// One byte per clock sustained while out_chan is ready; each byte passes the input register, then the result register.
// The byte is labelled between the input register and the result register,
// where the parser state updates in the same cycle.
// rst_n clears the parser state and both valid flags asynchronously.
// A stalled result holds the input register; ready falls only when both are full.
`default_nettype none

module amf0_stream_tokenizer_top #(
    parameter int unsigned MAX_MESSAGE = amf0_tok_pkg::MAX_MESSAGE_DEFAULT
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    amf0_tok_in_if.sink     in_chan,
    amf0_tok_out_if.source  out_chan
);

    logic                            in_valid_reg;
    logic [amf0_tok_pkg::BYTE_W-1:0] byte_reg;
    logic [amf0_tok_pkg::LEFT_W-1:0] left_reg;
    amf0_tok_pkg::amf0_state_t       state_reg;
    amf0_tok_pkg::amf0_state_t       state_next;
    amf0_tok_pkg::amf0_result_t      res_next;
    amf0_tok_pkg::amf0_result_t      res_reg;
    logic                            out_valid_reg;
    logic                            advance;

    assign advance       = in_valid_reg && (!out_valid_reg || out_chan.ready);
    assign in_chan.ready = !in_valid_reg || advance;

    amf0_tok_step #(
        .MAX_MESSAGE (MAX_MESSAGE)
    ) u_step (
        .byte_in    (byte_reg),
        .bytes_left (left_reg),
        .cur        (state_reg),
        .nxt        (state_next),
        .res        (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= amf0_tok_pkg::STATE_RESET;
        end
        else
        begin
            if (in_chan.ready)
            begin
                in_valid_reg <= in_chan.valid;
            end
            if (advance)
            begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_chan.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_chan.valid && in_chan.ready)
        begin
            byte_reg <= in_chan.byte_in;
            left_reg <= in_chan.bytes_left;
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign out_chan.valid        = out_valid_reg;
    assign out_chan.role         = res_reg.role;
    assign out_chan.data_byte    = res_reg.data_byte;
    assign out_chan.in_object    = res_reg.in_object;
    assign out_chan.field_done   = res_reg.field_done;
    assign out_chan.number_bits  = res_reg.number_bits;
    assign out_chan.length_value = res_reg.length_value;
    assign out_chan.error        = res_reg.error;

endmodule

`default_nettype wire

### design/amf0_tok_checker.sv
// Port-level checker for the AMF0 stream tokenizer, bound to the top level.
// Depends on amf0_tok_pkg and amf0_stream_tokenizer_top_defines.svh.
`default_nettype none

`include "amf0_stream_tokenizer_top_defines.svh"

module amf0_tok_checker (
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            out_valid,
    input wire logic                            out_ready,
    input wire logic [amf0_tok_pkg::ROLE_W-1:0] role,
    input wire logic                            field_done,
    input wire logic [amf0_tok_pkg::NUM_W-1:0]  number_bits,
    input wire logic [amf0_tok_pkg::LEFT_W-1:0] length_value,
    input wire logic                            error
);

    `AMF0_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(role), "result dropped or changed while stalled")
    `AMF0_ASSERT_NOW(a_err_role, out_valid && error, role == amf0_tok_pkg::ROLE_UNKNOWN && !field_done, "error on a byte that is not an unknown marker")
    `AMF0_ASSERT_NOW(a_num_only, out_valid && role != amf0_tok_pkg::ROLE_NUM_BYTE, number_bits == '0, "number bits outside a number byte")
    `AMF0_ASSERT_NOW(a_len_only, out_valid && length_value != '0, field_done && (role == amf0_tok_pkg::ROLE_STR_LEN || role == amf0_tok_pkg::ROLE_NAME_LEN), "length shown off the second length byte")

endmodule

bind amf0_stream_tokenizer_top amf0_tok_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_chan.valid),
    .out_ready    (out_chan.ready),
    .role         (out_chan.role),
    .field_done   (out_chan.field_done),
    .number_bits  (out_chan.number_bits),
    .length_value (out_chan.length_value),
    .error        (out_chan.error)
);

`default_nettype wire

### bench/amf0_stream_tokenizer_top_tb.sv
`timescale 1ns / 100ps
// Testbench for amf0_stream_tokenizer_top: directed bytes, then random AMF0 messages.
// Expected labels come from a behavioral byte labeler. Depends on amf0_tok_pkg, amf0_tok_if.

module amf0_stream_tokenizer_top_tb;

    import amf0_tok_pkg::*;

    localparam int unsigned CLK_HALF     = 4;
    localparam int unsigned RESET_CYCLES = 9;
    localparam int unsigned RANDOM_ITEMS = 400;
    localparam int unsigned HOLD_LEN     = 64;
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned DRAIN_LIMIT  = 5000;
    localparam int unsigned PRINT_LIMIT  = 30;
    localparam int unsigned COUNT_MAX    = MAX_MESSAGE_DEFAULT - 1;

    typedef struct {
        logic [BYTE_W-1:0] b;
        logic [LEFT_W-1:0] left;
        bit                typed;
        amf0_result_t      label;
    } dir_entry_t;

    logic clk;
    logic rst_n;

    amf0_tok_in_if  in_chan ();
    amf0_tok_out_if out_chan ();

    amf0_stream_tokenizer_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_chan  (in_chan),
        .out_chan (out_chan)
    );

    amf0_state_t       tok_state;
    amf0_result_t      labels_due[$];
    logic [BYTE_W-1:0] msg_bytes[$];
    dir_entry_t        dir_table[$];

    int unsigned mismatches;
    int unsigned results_seen;
    int unsigned cycle_count;
    int unsigned hold_cycles;
    int unsigned stall_left;
    bit          burst_mode;
    bit          hold_req;
    bit          hold_done;

    always #(CLK_HALF) clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // ---------------------------------------------------------------- labeler

    function automatic void finish_value();
        tok_state.member_pending = 1'b0;
        tok_state.phase = tok_state.object_open ? PH_NLEN_HI : PH_MARKER;
    endfunction

    function automatic void take_marker(input logic [BYTE_W-1:0] b, input logic member,
                                        inout amf0_result_t r);
        r.in_object = member;
        r.field_done = 1'b1;
        tok_state.member_pending = member;
        case (b)
            MARK_NUMBER:
            begin
                r.role = ROLE_NUM_MARKER;
                tok_state.phase = PH_NUM;
                tok_state.bytes_to_go = NUM_BYTES;
                tok_state.number_shift = '0;
            end
            MARK_BOOLEAN:
            begin
                r.role = ROLE_BOOL_MARKER;
                tok_state.phase = PH_BOOL;
            end
            MARK_STRING:
            begin
                r.role = ROLE_STR_MARKER;
                tok_state.phase = PH_SLEN_HI;
            end
            MARK_OBJECT:
            begin
                r.role = ROLE_OBJ_MARKER;
                tok_state.object_open = 1'b1;
                tok_state.member_pending = 1'b0;
                tok_state.phase = PH_NLEN_HI;
            end
            MARK_NULL:
            begin
                r.role = ROLE_NULL;
                finish_value();
            end
            default:
            begin
                r.role = ROLE_UNKNOWN;
                r.error = 1'b1;
                r.field_done = 1'b0;
                tok_state.object_open = 1'b0;
                tok_state.member_pending = 1'b0;
                tok_state.phase = PH_SKIP;
            end
        endcase
    endfunction

    function automatic amf0_result_t label_byte(input logic [BYTE_W-1:0] b,
                                                input logic [LEFT_W-1:0] left_raw);
        amf0_result_t      r;
        logic [LEFT_W-1:0] left;
        logic [LEFT_W-1:0] len;
        left = (left_raw > COUNT_MAX) ? LEFT_W'(COUNT_MAX) : left_raw;
        r = '0;
        r.role = ROLE_SKIPPED;
        r.data_byte = b;
        case (tok_state.phase)
            PH_MARKER:
                take_marker(b, tok_state.member_pending, r);
            PH_NUM:
            begin
                r.role = ROLE_NUM_BYTE;
                r.in_object = tok_state.member_pending;
                tok_state.number_shift = {tok_state.number_shift[NUM_W-BYTE_W-1:0], b};
                r.number_bits = tok_state.number_shift;
                if (tok_state.bytes_to_go <= 1)
                begin
                    tok_state.bytes_to_go = '0;
                    r.field_done = 1'b1;
                    finish_value();
                end
                else
                    tok_state.bytes_to_go--;
            end
            PH_BOOL:
            begin
                r.role = ROLE_BOOL_BYTE;
                r.in_object = tok_state.member_pending;
                r.field_done = 1'b1;
                finish_value();
            end
            PH_SLEN_HI:
            begin
                r.role = ROLE_STR_LEN;
                r.in_object = tok_state.member_pending;
                tok_state.length_high = b;
                tok_state.phase = PH_SLEN_LO;
            end
            PH_SLEN_LO:
            begin
                r.role = ROLE_STR_LEN;
                r.in_object = tok_state.member_pending;
                r.field_done = 1'b1;
                len = {tok_state.length_high, b};
                r.length_value = len;
                tok_state.bytes_to_go = len;
                if (len == 0)
                    finish_value();
                else
                    tok_state.phase = PH_STR;
            end
            PH_STR:
            begin
                r.role = ROLE_STR_BYTE;
                r.in_object = tok_state.member_pending;
                if (tok_state.bytes_to_go <= 1)
                begin
                    tok_state.bytes_to_go = '0;
                    r.field_done = 1'b1;
                    finish_value();
                end
                else
                    tok_state.bytes_to_go--;
            end
            PH_NLEN_HI:
            begin
                r.role = ROLE_NAME_LEN;
                r.in_object = 1'b1;
                tok_state.length_high = b;
                tok_state.phase = PH_NLEN_LO;
            end
            PH_NLEN_LO:
            begin
                r.role = ROLE_NAME_LEN;
                r.in_object = 1'b1;
                r.field_done = 1'b1;
                len = {tok_state.length_high, b};
                r.length_value = len;
                // a name that cannot fit in the message closes the object
                if (len >= left)
                begin
                    tok_state.object_open = 1'b0;
                    tok_state.member_pending = 1'b0;
                    tok_state.phase = PH_ENDB;
                end
                else if (len == 0)
                    tok_state.phase = PH_ZNAME;
                else
                begin
                    tok_state.bytes_to_go = len;
                    tok_state.phase = PH_NAME;
                end
            end
            PH_NAME:
            begin
                r.role = ROLE_NAME_BYTE;
                r.in_object = 1'b1;
                if (tok_state.bytes_to_go <= 1)
                begin
                    tok_state.bytes_to_go = '0;
                    r.field_done = 1'b1;
                    tok_state.member_pending = 1'b1;
                    tok_state.phase = PH_MARKER;
                end
                else
                    tok_state.bytes_to_go--;
            end
            PH_ZNAME:
            begin
                if (b == MARK_OBJ_END)
                begin
                    r.role = ROLE_OBJ_END;
                    r.field_done = 1'b1;
                    tok_state.object_open = 1'b0;
                    tok_state.member_pending = 1'b0;
                    tok_state.phase = PH_MARKER;
                end
                else
                    take_marker(b, 1'b1, r);
            end
            PH_ENDB:
            begin
                r.role = ROLE_OBJ_END;
                r.field_done = 1'b1;
                tok_state.phase = PH_MARKER;
            end
            default:
                r.role = ROLE_SKIPPED;
        endcase
        if (left == 0)
            tok_state = STATE_RESET;
        return r;
    endfunction

    // ---------------------------------------------------------------- helpers

    function automatic amf0_result_t typed_label(input logic [ROLE_W-1:0] role,
                                                 input logic [BYTE_W-1:0] b,
                                                 input logic inobj, input logic done,
                                                 input logic err);
        amf0_result_t r;
        r = '0;
        r.role = role;
        r.data_byte = b;
        r.in_object = inobj;
        r.field_done = done;
        r.error = err;
        return r;
    endfunction

    function automatic dir_entry_t dir_entry(input logic [BYTE_W-1:0] b,
                                             input logic [LEFT_W-1:0] left,
                                             input bit typed, input amf0_result_t label);
        dir_entry_t e;
        e.b = b;
        e.left = left;
        e.typed = typed;
        e.label = label;
        return e;
    endfunction

    function automatic logic [BYTE_W-1:0] rand_byte();
        return BYTE_W'($urandom_range(0, 255));
    endfunction

    // mostly no gap, some short ones, a few long ones
    function automatic int unsigned idle_len();
        int unsigned r;
        if (burst_mode || (hold_req && !hold_done))
            return 0;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic report_mismatch(input string what, input logic [NUM_W-1:0] got,
                                   input logic [NUM_W-1:0] want);
        if (mismatches < PRINT_LIMIT)
            $display("mismatch %s at result %0d: got %0h expected %0h",
                     what, results_seen, got, want);
        mismatches++;
    endtask

    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic [LEFT_W-1:0] left,
                             input bit typed, input amf0_result_t label);
        amf0_result_t predicted;
        int unsigned  gap;
        gap = idle_len();
        @(negedge clk);
        if (gap > 0)
        begin
            in_chan.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_chan.valid      <= 1'b1;
        in_chan.byte_in    <= b;
        in_chan.bytes_left <= left;
        do
            @(posedge clk);
        while (in_chan.ready !== 1'b1);
        predicted = label_byte(b, left);
        labels_due.push_back(typed ? label : predicted);
    endtask

    // ---------------------------------------------------------------- message builder

    function automatic void push_value(input bit allow_object);
        int unsigned k;
        int unsigned n;
        k = $urandom_range(0, allow_object ? 4 : 3);
        case (k)
            0:
            begin
                msg_bytes.push_back(MARK_NUMBER);
                repeat (NUM_BYTES) msg_bytes.push_back(rand_byte());
            end
            1:
            begin
                msg_bytes.push_back(MARK_BOOLEAN);
                msg_bytes.push_back(rand_byte());
            end
            2:
            begin
                n = $urandom_range(0, 5);
                msg_bytes.push_back(MARK_STRING);
                msg_bytes.push_back(8'h00);
                msg_bytes.push_back(BYTE_W'(n));
                repeat (n) msg_bytes.push_back(rand_byte());
            end
            3:
                msg_bytes.push_back(MARK_NULL);
            default:
                msg_bytes.push_back(MARK_OBJECT);
        endcase
    endfunction

    function automatic void push_object();
        int unsigned members;
        int unsigned name_len;
        logic [LEFT_W-1:0] big_len;
        members = $urandom_range(0, 3);
        msg_bytes.push_back(MARK_OBJECT);
        repeat (members)
        begin
            name_len = $urandom_range(0, 4);
            msg_bytes.push_back(8'h00);
            msg_bytes.push_back(BYTE_W'(name_len));
            repeat (name_len) msg_bytes.push_back(rand_byte());
            // an object marker here is labelled but not entered
            push_value($urandom_range(0, 5) == 0);
        end
        if ($urandom_range(0, 3) != 0)
        begin
            msg_bytes.push_back(8'h00);
            msg_bytes.push_back(8'h00);
            msg_bytes.push_back(MARK_OBJ_END);
        end
        else
        begin
            // name length beyond the message: closes, next byte is the end byte
            big_len = LEFT_W'($urandom_range(256, 65535));
            msg_bytes.push_back(big_len[15:8]);
            msg_bytes.push_back(big_len[7:0]);
            msg_bytes.push_back(rand_byte());
        end
    endfunction

    function automatic void build_message();
        int unsigned kind;
        int unsigned count;
        int unsigned cut;
        logic [LEFT_W-1:0] big_len;
        msg_bytes.delete();
        kind = $urandom_range(0, 11);
        case (kind)
            0:
                repeat ($urandom_range(1, 6)) msg_bytes.push_back(rand_byte());
            1:
            begin
                if ($urandom_range(0, 1))
                    push_value(1'b0);
                msg_bytes.push_back(($urandom_range(0, 7) == 0) ? 8'h04
                                                                : BYTE_W'($urandom_range(6, 255)));
                repeat ($urandom_range(0, 4)) msg_bytes.push_back(rand_byte());
            end
            2:
            begin
                // long string cut short by the message end
                big_len = LEFT_W'($urandom_range(0, 65535));
                msg_bytes.push_back(MARK_STRING);
                msg_bytes.push_back(big_len[15:8]);
                msg_bytes.push_back(big_len[7:0]);
                repeat ($urandom_range(0, 3)) msg_bytes.push_back(rand_byte());
            end
            default:
            begin
                count = $urandom_range(1, 3);
                repeat (count)
                    if ($urandom_range(0, 9) < 4)
                        push_object();
                    else
                        push_value(1'b0);
            end
        endcase
        if (msg_bytes.size() > 1 && $urandom_range(0, 5) == 0)
        begin
            cut = $urandom_range(1, msg_bytes.size() - 1);
            while (msg_bytes.size() > cut)
                void'(msg_bytes.pop_back());
        end
    endfunction

    // ---------------------------------------------------------------- result side

    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_done)
            begin
                out_chan.ready <= 1'b0;
                hold_cycles++;
                if (hold_cycles >= HOLD_LEN)
                    hold_done = 1'b1;
            end
            else if (stall_left > 0)
            begin
                out_chan.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                out_chan.ready <= 1'b1;
                stall_left = idle_len();
            end
        end
    end

    always @(posedge clk)
    begin
        amf0_result_t want;
        if (rst_n && out_chan.valid === 1'b1 && out_chan.ready === 1'b1)
        begin
            if (labels_due.size() == 0)
                report_mismatch("unexpected transaction", NUM_W'(out_chan.role), '0);
            else
            begin
                want = labels_due.pop_front();
                if (out_chan.role !== want.role)
                    report_mismatch("role", NUM_W'(out_chan.role), NUM_W'(want.role));
                if (out_chan.data_byte !== want.data_byte)
                    report_mismatch("data_byte", NUM_W'(out_chan.data_byte),
                                    NUM_W'(want.data_byte));
                if (out_chan.in_object !== want.in_object)
                    report_mismatch("in_object", NUM_W'(out_chan.in_object),
                                    NUM_W'(want.in_object));
                if (out_chan.field_done !== want.field_done)
                    report_mismatch("field_done", NUM_W'(out_chan.field_done),
                                    NUM_W'(want.field_done));
                if (out_chan.number_bits !== want.number_bits)
                    report_mismatch("number_bits", out_chan.number_bits, want.number_bits);
                if (out_chan.length_value !== want.length_value)
                    report_mismatch("length_value", NUM_W'(out_chan.length_value),
                                    NUM_W'(want.length_value));
                if (out_chan.error !== want.error)
                    report_mismatch("error", NUM_W'(out_chan.error), NUM_W'(want.error));
            end
            results_seen++;
        end
    end

    // ---------------------------------------------------------------- stimulus

    initial
    begin
        int unsigned random_sent;
        int unsigned waited;
        int unsigned left;
        clk = 1'b0;
        rst_n = 1'b0;
        in_chan.valid = 1'b0;
        in_chan.byte_in = '0;
        in_chan.bytes_left = '0;
        out_chan.ready = 1'b0;
        tok_state = STATE_RESET;
        mismatches = 0;
        results_seen = 0;
        cycle_count = 0;
        hold_cycles = 0;
        stall_left = 0;
        burst_mode = 1'b0;
        hold_req = 1'b0;
        hold_done = 1'b0;
        random_sent = 0;
        waited = 0;

        // null, unknown marker with skipped tail
        dir_table.push_back(dir_entry(MARK_NULL, 16'd0, 1'b1,
                                      typed_label(ROLE_NULL, MARK_NULL, 1'b0, 1'b1, 1'b0)));
        dir_table.push_back(dir_entry(8'hFF, 16'd2, 1'b1,
                                      typed_label(ROLE_UNKNOWN, 8'hFF, 1'b0, 1'b0, 1'b1)));
        dir_table.push_back(dir_entry(8'h00, 16'd1, 1'b1,
                                      typed_label(ROLE_SKIPPED, 8'h00, 1'b0, 1'b0, 1'b0)));
        dir_table.push_back(dir_entry(8'hFF, 16'd0, 1'b1,
                                      typed_label(ROLE_SKIPPED, 8'hFF, 1'b0, 1'b0, 1'b0)));
        // number with extreme byte values
        dir_table.push_back(dir_entry(MARK_NUMBER, 16'd8, 1'b0, '0));
        dir_table.push_back(dir_entry(8'hFF, 16'd7, 1'b0, '0));
        dir_table.push_back(dir_entry(8'h00, 16'd6, 1'b0, '0));
        dir_table.push_back(dir_entry(8'hFF, 16'd5, 1'b0, '0));
        dir_table.push_back(dir_entry(8'h80, 16'd4, 1'b0, '0));
        dir_table.push_back(dir_entry(8'h01, 16'd3, 1'b0, '0));
        dir_table.push_back(dir_entry(8'h7F, 16'd2, 1'b0, '0));
        dir_table.push_back(dir_entry(8'hAA, 16'd1, 1'b0, '0));
        dir_table.push_back(dir_entry(8'h55, 16'd0, 1'b0, '0));
        // object under an oversized count, closed by empty name then end marker
        dir_table.push_back(dir_entry(MARK_OBJECT, 16'hFFFF, 1'b0, '0));
        dir_table.push_back(dir_entry(8'h00, 16'd3, 1'b0, '0));
        dir_table.push_back(dir_entry(8'h00, 16'd2, 1'b0, '0));
        dir_table.push_back(dir_entry(MARK_OBJ_END, 16'd1, 1'b1,
                                      typed_label(ROLE_OBJ_END, MARK_OBJ_END,
                                                  1'b0, 1'b1, 1'b0)));
        dir_table.push_back(dir_entry(MARK_BOOLEAN, 16'd1, 1'b0, '0));
        dir_table.push_back(dir_entry(8'h01, 16'd0, 1'b0, '0));
        // zero-length string
        dir_table.push_back(dir_entry(MARK_STRING, 16'd2, 1'b0, '0));
        dir_table.push_back(dir_entry(8'h00, 16'd1, 1'b0, '0));
        dir_table.push_back(dir_entry(8'h00, 16'd0, 1'b0, '0));
        // name length past the message end
        dir_table.push_back(dir_entry(MARK_OBJECT, 16'd3, 1'b0, '0));
        dir_table.push_back(dir_entry(8'h00, 16'd2, 1'b0, '0));
        dir_table.push_back(dir_entry(8'h05, 16'd1, 1'b0, '0));
        dir_table.push_back(dir_entry(8'hAA, 16'd0, 1'b1,
                                      typed_label(ROLE_OBJ_END, 8'hAA, 1'b0, 1'b1, 1'b0)));

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_table[i])
            send_byte(dir_table[i].b, dir_table[i].left, dir_table[i].typed,
                      dir_table[i].label);

        // long receiver hold-off while the sender keeps offering bytes
        hold_req = 1'b1;
        while (random_sent < RANDOM_ITEMS)
        begin
            build_message();
            burst_mode = ($urandom_range(0, 3) == 0);
            foreach (msg_bytes[i])
            begin
                left = msg_bytes.size() - 1 - i;
                if (left != 0 && $urandom_range(0, 7) == 0)
                    left = $urandom_range(left, 65535);
                send_byte(msg_bytes[i], LEFT_W'(left), 1'b0, '0);
            end
            random_sent += msg_bytes.size();
        end
        burst_mode = 1'b0;

        @(negedge clk);
        in_chan.valid <= 1'b0;
        while (labels_due.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (8) @(posedge clk);
        if (labels_due.size() != 0)
            report_mismatch("transactions never seen", NUM_W'(labels_due.size()), '0);

        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
